@@ src/b64e_pkg.sv @@
// shared types, constants and the character mapping of the base64 stream encoder
// no dependencies; used by every module of the block by scoped names
package b64e_pkg;

    // depth of the job queue between front and back
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR    = 8'd61;
    localparam logic [7:0] C62_RESET   = 8'd43;
    localparam logic [7:0] C63_RESET   = 8'd47;

    // configuration register indexes
    localparam logic CFG_CHAR_62 = 1'b0;
    localparam logic CFG_CHAR_63 = 1'b1;

    // one output symbol: a six-bit value or a pad
    typedef struct packed {
        logic       pad;
        logic [5:0] val;
    } t_sym;

    // all symbols caused by one input byte
    typedef struct packed {
        t_sym [3:0] sym;
        logic [1:0] last_idx;
        logic       fin;
    } t_job;

    function automatic logic [7:0] sextet_to_char(
        input t_sym       s,
        input logic [7:0] c62,
        input logic [7:0] c63
    );
        logic [7:0] v;
        logic [7:0] ch;
        v = {2'b00, s.val};
        if (s.pad) begin
            ch = PAD_CHAR;
        end else if (v < 8'd26) begin
            ch = v + 8'd65;
        end else if (v < 8'd52) begin
            ch = v + 8'd71;
        end else if (v < 8'd62) begin
            ch = v - 8'd4;
        end else if (v == 8'd62) begin
            ch = c62;
        end else begin
            ch = c63;
        end
        return ch;
    endfunction

endpackage

@@ src/b64e_front.sv @@
// front part: tracks the position in the 3-byte group and splits each byte into symbols
// depends on b64e_pkg
module b64e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_byte,
    input  logic            i_fin,
    output b64e_pkg::t_job  o_job
);

    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [5:0] r_carry, n_carry;
    b64e_pkg::t_job job;

    always_comb begin
        job = '0;
        job.fin = i_fin;
        n_phase = PH1;
        n_carry = {i_byte[1:0], 4'b0000};
        case (r_phase)
            PH1: begin
                job.sym[0].val = r_carry | {2'b00, i_byte[7:4]};
                job.sym[1].val = {i_byte[3:0], 2'b00};
                job.sym[2].pad = 1'b1;
                job.last_idx   = i_fin ? 2'd2 : 2'd0;
                n_carry        = {i_byte[3:0], 2'b00};
                n_phase        = PH2;
            end
            PH2: begin
                job.sym[0].val = r_carry | {4'b0000, i_byte[7:6]};
                job.sym[1].val = i_byte[5:0];
                job.last_idx   = 2'd1;
                n_carry        = '0;
                n_phase        = PH0;
            end
            default: begin
                // group start, also the unused fourth phase code
                job.sym[0].val = i_byte[7:2];
                job.sym[1].val = {i_byte[1:0], 4'b0000};
                job.sym[2].pad = 1'b1;
                job.sym[3].pad = 1'b1;
                job.last_idx   = i_fin ? 2'd3 : 2'd0;
            end
        endcase
        if (i_fin) begin
            n_phase = PH0;
            n_carry = '0;
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH0;
            r_carry <= '0;
        end else if (i_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

@@ src/b64e_fifo.sv @@
// short job queue between front and back
// depends on b64e_pkg
module b64e_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64e_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output b64e_pkg::t_job  o_data
);

    localparam int unsigned PTR_W = (b64e_pkg::FIFO_DEPTH > 1) ?
                                    $clog2(b64e_pkg::FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(b64e_pkg::FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(b64e_pkg::FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(b64e_pkg::FIFO_DEPTH);

    b64e_pkg::t_job   r_mem [b64e_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ src/b64e_back.sv @@
// back part: holds the configured codes and sends one character per cycle while jobs wait and the output is taken
// depends on b64e_pkg
module b64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_job_valid,
    input  b64e_pkg::t_job  i_job,
    output logic            o_job_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);

    logic [7:0]     r_c62, r_c63;
    b64e_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           r_busy;
    logic           r_out_valid;
    logic [7:0]     r_out_char;
    logic           r_out_last;
    logic           emit, done, load, at_last;

    assign at_last   = (r_idx == r_job.last_idx);
    assign emit      = r_busy && (!r_out_valid || i_tready);
    assign done      = emit && at_last;
    assign load      = i_job_valid && (!r_busy || done);
    assign o_job_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c62       <= b64e_pkg::C62_RESET;
            r_c63       <= b64e_pkg::C63_RESET;
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    b64e_pkg::CFG_CHAR_62: r_c62 <= i_cfg_data;
                    b64e_pkg::CFG_CHAR_63: r_c63 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out_char <= b64e_pkg::sextet_to_char(r_job.sym[r_idx], r_c62, r_c63);
            r_out_last <= r_job.fin && at_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_char;
    assign o_tlast  = r_out_last;

endmodule

@@ src/base64_stream_encoder_core.sv @@
// streaming base64 encoder, top level: front, job queue and back
// depends on b64e_pkg, b64e_front, b64e_fifo, b64e_back
//
// Takes a message one byte per transfer on s_axis, tlast on its final byte, and
// sends the Base64 text one character per transfer on m_axis, tlast on the final
// character. Characters leave as soon as their six bits are known: one for the
// first and second byte of a group, two for the third. A final byte in a short
// group adds the zero-filled character and '=' pads up to four characters. The
// codes for values 62 and 63 come from two registers (reset '+' and '/'), written
// through the cfg channel, index 0 and 1; the user must write them only while no
// message is in flight, which the block itself does not enforce.
// Rate: the back sends one character per cycle from its output register while
// m_axis is ready and jobs are queued. The front takes a byte in every cycle
// while the two-job queue has room; a lone byte passes the queue, the job
// register and the output register before its first character shows on m_axis.
module base64_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // final_byte
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,   // last_char
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    b64e_pkg::t_job front_job;
    b64e_pkg::t_job queue_job;
    logic           queue_full;
    logic           queue_valid;
    logic           queue_pop;
    logic           in_xfer;

    // input transfer goes straight into the queue
    assign s_axis_tready = !queue_full;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_byte  (s_axis_tdata),
        .i_fin   (s_axis_tlast),
        .o_job   (front_job)
    );

    b64e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_job)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

@@ src/b64e_checker.sv @@
// port-level checks of the base64 stream encoder, bound to the top level
// depends on b64e_pkg and base64_stream_encoder_core
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_cfg_index,
    input logic [7:0] i_cfg_data
);

    logic [7:0] r_c62, r_c63;
    logic       r_pad_open;
    logic       out_xfer;
    logic       pad_unique;

    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    assign pad_unique = (r_c62 != b64e_pkg::PAD_CHAR) && (r_c63 != b64e_pkg::PAD_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c62      <= b64e_pkg::C62_RESET;
            r_c63      <= b64e_pkg::C63_RESET;
            r_pad_open <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == b64e_pkg::CFG_CHAR_62) begin
                    r_c62 <= i_cfg_data;
                end else begin
                    r_c63 <= i_cfg_data;
                end
            end
            if (out_xfer) begin
                r_pad_open <= (m_axis_tdata == b64e_pkg::PAD_CHAR) && !m_axis_tlast
                              && pad_unique;
            end
        end
    end

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // every character belongs to the alphabet, the pad or the configured codes
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |->
            (m_axis_tdata >= 8'd65 && m_axis_tdata <= 8'd90) ||
            (m_axis_tdata >= 8'd97 && m_axis_tdata <= 8'd122) ||
            (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57) ||
            m_axis_tdata == b64e_pkg::PAD_CHAR ||
            m_axis_tdata == r_c62 || m_axis_tdata == r_c63)
        else $error("character outside the alphabet");

    // a pad that is not the end is followed by the final pad, checked while neither configured code is the pad
    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_pad_open |->
            m_axis_tdata == b64e_pkg::PAD_CHAR && m_axis_tlast)
        else $error("pad not followed by final pad");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (.*);

@@ verif/base64_stream_encoder_core_tb.sv @@
// testbench for base64_stream_encoder_core: directed and random messages, checked per character
// depends on b64e_pkg and base64_stream_encoder_core; self-contained otherwise
module base64_stream_encoder_core_tb;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_enc_char;

    // position of the next byte in its 3-byte group
    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2
    } t_grp_pos;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index   = 1'b0;
    logic [7:0] i_cfg_data    = 8'h00;

    // predictor state and its copy of the character registers
    t_grp_pos   grp_pos   = GRP_FIRST;
    logic [5:0] carry_sx  = 6'd0;
    logic [7:0] code_62   = b64e_pkg::C62_RESET;
    logic [7:0] code_63   = b64e_pkg::C63_RESET;

    t_enc_char   pending_chars[$];
    int unsigned err_count   = 0;
    bit          steady_flow = 1'b0;

    base64_stream_encoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26) return w + 8'd65;
        if (w < 8'd52) return w + 8'd71;
        if (w < 8'd62) return w - 8'd4;
        if (w == 8'd62) return code_62;
        return code_63;
    endfunction

    function automatic void queue_char(input logic [7:0] code, input logic last);
        t_enc_char c;
        c.code = code;
        c.last = last;
        pending_chars.push_back(c);
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (grp_pos)
            GRP_SECOND: begin
                queue_char(sextet_char(carry_sx | {2'b00, b[7:4]}), 1'b0);
                carry_sx = {b[3:0], 2'b00};
                grp_pos  = GRP_THIRD;
                if (fin) begin
                    queue_char(sextet_char(carry_sx), 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b1);
                end
            end
            GRP_THIRD: begin
                queue_char(sextet_char(carry_sx | {4'b0000, b[7:6]}), 1'b0);
                queue_char(sextet_char(b[5:0]), fin);
                carry_sx = 6'd0;
                grp_pos  = GRP_FIRST;
            end
            default: begin
                // an unused position code counts as the start of a group
                queue_char(sextet_char(b[7:2]), 1'b0);
                carry_sx = {b[1:0], 4'b0000};
                grp_pos  = GRP_SECOND;
                if (fin) begin
                    queue_char(sextet_char(carry_sx), 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b1);
                end
            end
        endcase
        if (fin) begin
            grp_pos  = GRP_FIRST;
            carry_sx = 6'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls and the character check
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin : char_check
        t_enc_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_axis_tdata !== want.code) begin
                    $display("%0t: out_char mismatch: expected %h, got %h",
                             $time, want.code, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last_char mismatch: expected %b, got %b",
                             $time, want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------
    // leaves tvalid high so back-to-back bytes keep a steady valid
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady_flow && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        encode_byte(b, fin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_message(input logic [7:0] bytes[$]);
        for (int k = 0; k < bytes.size(); k++) begin
            send_byte(bytes[k], k == bytes.size() - 1);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == b64e_pkg::CFG_CHAR_62) code_62 = val;
        else code_63 = val;
        @(negedge i_clk);
    endtask

    // registers change only once the encoder has gone quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_char_codes(input logic [7:0] c62, input logic [7:0] c63);
        wait_idle();
        write_reg(b64e_pkg::CFG_CHAR_62, c62);
        write_reg(b64e_pkg::CFG_CHAR_63, c63);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // one- and two-byte messages: zero fill plus two or one pad
    task automatic test_short_groups();
        send_message('{8'h00});
        send_message('{8'hff});
        send_message('{8'hff, 8'h00});
        send_message('{8'h00, 8'hff});
    endtask

    // whole groups, all-62 and all-63 sextets, and a message crossing groups
    task automatic test_full_groups();
        send_message('{8'hfb, 8'hef, 8'hbe});
        send_message('{8'hff, 8'hff, 8'hff});
        send_message('{8'h00, 8'h10, 8'h83});
        send_message('{8'h4d, 8'h61, 8'h6e, 8'h20});
    endtask

    // sextets on the letter and digit boundaries: 25, 26, 51, 52 and 61
    task automatic test_alphabet_edges();
        send_message('{8'h65, 8'hac, 8'hf4});
        send_message('{8'hf7});
    endtask

    // character registers at their extremes, then back to the defaults
    task automatic test_char_registers();
        set_char_codes(8'h00, 8'hff);
        send_message('{8'hfb, 8'hff, 8'hff});
        set_char_codes(8'hff, 8'h00);
        send_message('{8'hfb, 8'hff, 8'hff});
        set_char_codes(b64e_pkg::C62_RESET, b64e_pkg::C63_RESET);
    endtask

    // random messages, mostly short, with register changes between some of them
    task automatic test_random_messages();
        int unsigned sent;
        int unsigned len;
        int unsigned next_cfg;
        logic [7:0]  msg[$];
        sent     = 0;
        next_cfg = 120;
        while (sent < 450) begin
            if (sent >= next_cfg) begin
                set_char_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
                next_cfg += 120;
            end
            // one long stretch with neither side holding back
            steady_flow = (sent >= 200 && sent < 300);
            len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
            msg.delete();
            repeat (len) msg.push_back(8'($urandom_range(255)));
            send_message(msg);
            sent += len;
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_short_groups();
        test_full_groups();
        test_alphabet_edges();
        test_char_registers();
        test_random_messages();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d characters missing, first expected %h",
                     $time, pending_chars.size(), pending_chars[0].code);
            err_count++;
        end
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2400000;
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
